### design/bma_pkg.sv
package bma_pkg;

    localparam int SAMPLE_WIDTH      = 32;
    localparam int MAX_WINDOW_LOG2   = 5;
    localparam int STORE_DEPTH       = 1 << MAX_WINDOW_LOG2;
    localparam int POS_WIDTH         = (MAX_WINDOW_LOG2 < 1) ? 1 : MAX_WINDOW_LOG2;
    localparam int LOG2_WIDTH        = 3;
    localparam int LG_WIDTH          = (MAX_WINDOW_LOG2 < 2) ? 1 : $clog2(MAX_WINDOW_LOG2 + 1);
    localparam int SUM_WIDTH         = SAMPLE_WIDTH + MAX_WINDOW_LOG2;
    localparam int WINDOW_LOG2_RESET = 3;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef logic [POS_WIDTH-1:0]           pos_t;
    typedef logic [LOG2_WIDTH-1:0]          log2_t;
    typedef logic [LG_WIDTH-1:0]            lg_t;
    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [SUM_WIDTH-1:0]    sum_t;

    typedef struct packed {
        logic    accept;
        logic    clear;
        sample_t sample;
        pos_t    addr;
        logic    old_valid;
        logic    fwd;
    } issue_t;

    typedef struct packed {
        logic    write;
        logic    clear;
        pos_t    addr;
        sample_t data;
        logic    s1_sample;
        logic    s1_clear;
        pos_t    s1_addr;
    } commit_t;

    function automatic lg_t effective_log2(input log2_t raw);
        lg_t lg;
        if (int'(raw) > MAX_WINDOW_LOG2)
        begin
            lg = lg_t'(MAX_WINDOW_LOG2);
        end
        else
        begin
            lg = lg_t'(raw);
        end
        return lg;
    endfunction

    function automatic pos_t window_mask(input lg_t lg);
        pos_t all_ones;
        all_ones = '1;
        return ~(all_ones << lg);
    endfunction

endpackage

### design/bma_if.sv
interface bma_sample_if;
    import bma_pkg::*;

    logic    valid;
    logic    ready;
    logic    req_type;
    sample_t sample;

    modport source (output valid, output req_type, output sample, input ready);
    modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface bma_result_if;
    import bma_pkg::*;

    logic    valid;
    logic    ready;
    sample_t average;
    sum_t    window_sum;

    modport source (output valid, output average, output window_sum, input ready);
    modport sink   (input valid, input average, input window_sum, output ready);
endinterface

### design/bma_ram.sv
module bma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/bma_accum.sv
module bma_accum (
    input  logic              clk,
    input  logic              rst_n,
    input  bma_pkg::issue_t   issue,
    input  bma_pkg::sample_t  rdata,
    input  bma_pkg::lg_t      lg,
    input  logic              cfg_clear,
    input  logic              out_ready,
    output bma_pkg::commit_t  commit,
    output logic              issue_ready,
    output logic              out_valid,
    output bma_pkg::sample_t  average,
    output bma_pkg::sum_t     window_sum
);
    import bma_pkg::*;

    logic    s1_valid_reg, s1_valid_next;
    logic    s1_clear_reg, s1_clear_next;
    sample_t s1_sample_reg, s1_sample_next;
    pos_t    s1_addr_reg, s1_addr_next;
    logic    s1_old_valid_reg, s1_old_valid_next;
    logic    s1_fwd_reg, s1_fwd_next;
    sample_t fwd_data_reg, fwd_data_next;
    sum_t    sum_reg, sum_next;
    logic    out_valid_reg, out_valid_next;
    sample_t avg_reg, avg_next;
    sum_t    osum_reg, osum_next;

    logic    out_free;
    logic    advance;
    sample_t old_sample;
    sum_t    sum_upd;

    assign out_free    = !out_valid_reg || out_ready;
    assign advance     = s1_valid_reg && out_free;
    assign issue_ready = !s1_valid_reg || out_free;

    always_comb
    begin
        old_sample = s1_fwd_reg ? fwd_data_reg : (s1_old_valid_reg ? rdata : '0);
        sum_upd    = s1_clear_reg ? '0
                   : sum_reg + sum_t'(s1_sample_reg) - sum_t'(old_sample);
    end

    always_comb
    begin
        s1_valid_next     = issue.accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        s1_clear_next     = issue.accept ? issue.clear : s1_clear_reg;
        s1_sample_next    = issue.accept ? issue.sample : s1_sample_reg;
        s1_addr_next      = issue.accept ? issue.addr : s1_addr_reg;
        s1_old_valid_next = issue.accept ? issue.old_valid : s1_old_valid_reg;
        s1_fwd_next       = issue.accept ? issue.fwd : s1_fwd_reg;
        fwd_data_next     = issue.accept ? s1_sample_reg : fwd_data_reg;

        if (cfg_clear)
        begin
            sum_next = '0;
        end
        else if (advance)
        begin
            sum_next = sum_upd;
        end
        else
        begin
            sum_next = sum_reg;
        end

        out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        avg_next       = advance ? sample_t'(sum_upd >>> lg) : avg_reg;
        osum_next      = advance ? sum_upd : osum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_clear_reg     <= s1_clear_next;
        s1_sample_reg    <= s1_sample_next;
        s1_addr_reg      <= s1_addr_next;
        s1_old_valid_reg <= s1_old_valid_next;
        s1_fwd_reg       <= s1_fwd_next;
        fwd_data_reg     <= fwd_data_next;
        avg_reg          <= avg_next;
        osum_reg         <= osum_next;
    end

    always_comb
    begin
        commit.write     = advance && !s1_clear_reg;
        commit.clear     = advance && s1_clear_reg;
        commit.addr      = s1_addr_reg;
        commit.data      = s1_sample_reg;
        commit.s1_sample = s1_valid_reg && !s1_clear_reg;
        commit.s1_clear  = s1_valid_reg && s1_clear_reg;
        commit.s1_addr   = s1_addr_reg;
    end

    assign out_valid  = out_valid_reg;
    assign average    = avg_reg;
    assign window_sum = osum_reg;

    a_clear_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_clear_reg |=> out_valid_reg && avg_reg == '0 && osum_reg == '0)
        else $error("clear beat did not produce a zero result");

    a_cfg_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_clear |=> sum_reg == '0)
        else $error("window change left a stale sum");

endmodule

### design/boxcar_moving_average.sv
// An accepted beat is registered into stage 1 with its RAM read, then its update into the result.
// Throughput: one beat per cycle while results are taken; the sample RAM takes one read and one
// write per cycle, with the previous beat's write forwarded when both hit the same entry.
// Reset: window_log2 returns to 3, the position and running sum to zero, and every
// store entry is marked empty so it reads as zero; no clearing pass is needed.
module boxcar_moving_average (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  bma_pkg::log2_t        cfg_wdata,
    bma_sample_if.sink            sample_ch,
    bma_result_if.source          result_ch
);
    import bma_pkg::*;

    log2_t                  window_log2_reg, window_log2_next;
    pos_t                   pos_reg, pos_next;
    logic [STORE_DEPTH-1:0] valid_reg, valid_next;

    lg_t     lg;
    pos_t    mask;
    pos_t    rd_pos;
    logic    accept;
    logic    issue_ready;
    issue_t  issue;
    commit_t commit;
    sample_t rdata;

    assign lg     = effective_log2(window_log2_reg);
    assign mask   = window_mask(lg);
    assign rd_pos = pos_reg & mask;

    assign sample_ch.ready = issue_ready;
    assign accept          = sample_ch.valid && issue_ready;

    always_comb
    begin
        issue.accept    = accept;
        issue.clear     = (sample_ch.req_type == REQ_CLEAR);
        issue.sample    = sample_ch.sample;
        issue.addr      = rd_pos;
        issue.old_valid = valid_reg[rd_pos] && !commit.s1_clear;
        issue.fwd       = commit.s1_sample && (commit.s1_addr == rd_pos);
    end

    always_comb
    begin
        window_log2_next = cfg_we ? cfg_wdata : window_log2_reg;

        if (cfg_we)
        begin
            pos_next = '0;
        end
        else if (accept)
        begin
            pos_next = issue.clear ? '0 : ((rd_pos + pos_t'(1)) & mask);
        end
        else
        begin
            pos_next = pos_reg;
        end

        valid_next = valid_reg;
        if (cfg_we || commit.clear)
        begin
            valid_next = '0;
        end
        else if (commit.write)
        begin
            valid_next[commit.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_log2_reg <= log2_t'(WINDOW_LOG2_RESET);
            pos_reg         <= '0;
            valid_reg       <= '0;
        end
        else
        begin
            window_log2_reg <= window_log2_next;
            pos_reg         <= pos_next;
            valid_reg       <= valid_next;
        end
    end

    bma_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (commit.write),
        .waddr (commit.addr),
        .wdata (commit.data),
        .re    (accept),
        .raddr (rd_pos),
        .rdata (rdata)
    );

    bma_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .rdata       (rdata),
        .lg          (lg),
        .cfg_clear   (cfg_we),
        .out_ready   (result_ch.ready),
        .commit      (commit),
        .issue_ready (issue_ready),
        .out_valid   (result_ch.valid),
        .average     (result_ch.average),
        .window_sum  (result_ch.window_sum)
    );

    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg & ~mask) == '0)
        else $error("write position outside the window");

    a_cfg_empties_store: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> valid_reg == '0)
        else $error("window change left store entries marked valid");

    a_clear_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && sample_ch.req_type == REQ_CLEAR |=> pos_reg == '0)
        else $error("clear beat did not rewind the write position");

endmodule
